// ===== rtl/rlbt_pkg.sv =====
// Package for the run-length blob tracker: table sizing, entry type, codes.
// No dependencies.
package rlbt_pkg;

  localparam int MaxObjects = 8;
  localparam int SlotW = $clog2(MaxObjects);
  localparam int CountW = $clog2(MaxObjects + 1);

  localparam logic [1:0] RegLineWidth = 2'd0;
  localparam logic [1:0] RegFrameLines = 2'd1;
  localparam logic [1:0] RegMinRunWidth = 2'd2;
  localparam logic [1:0] RegMinHeight = 2'd3;

  localparam logic [7:0] PktHead = 8'h0A;
  localparam logic [7:0] PktTail = 8'hFF;

  typedef struct packed {
    logic [7:0] color;
    logic [7:0] span_lo;
    logic [7:0] span_hi;
    logic [7:0] left;
    logic [7:0] top;
    logic [7:0] right;
    logic [7:0] bottom;
  } blob_t;

  function automatic logic [7:0] color_index(input logic [7:0] c);
    logic [7:0] r;
    r = 8'd0;
    for (int k = 0; k < 8; k++) begin
      if (c == (8'd128 >> k)) r = 8'(k);
    end
    return r;
  endfunction

endpackage

// ===== rtl/run_length_blob_tracker.sv =====
// Run-length blob tracker top level: sequencer, object table, report output.
// Depends on rlbt_pkg.
//
//  channel | dir | handshake                  | payload
//  s_axis  | in  | s_axis_tvalid/tready       | tdata {run_length, color_mask}, tuser action
//  m_axis  | out | m_axis_tvalid/tready       | tdata report_byte, tlast last
//  apb     | in  | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// A run visits the table one slot a cycle through a shared compare unit: it
// scans for a merge, then, if none hits and the table is not full, for a free
// slot, then takes the line step. Every eighth line end sweeps the table for
// the height filter. A frame report streams one byte per cycle when taken and
// not seeking the next valid slot; then the table is cleared. Reset is
// synchronous; the input is not ready until the run and any report are done.
module run_length_blob_tracker
  import rlbt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] color_mask, [15:8] run_length
  input  logic        s_axis_tuser,  // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] report_byte
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMerge = 3'd1;
  localparam logic [2:0] StFree = 3'd2;
  localparam logic [2:0] StLine = 3'd3;
  localparam logic [2:0] StFilter = 3'd4;
  localparam logic [2:0] StReport = 3'd5;

  localparam logic [2:0] PhHead = 3'd0;
  localparam logic [2:0] PhCount = 3'd1;
  localparam logic [2:0] PhField = 3'd2;
  localparam logic [2:0] PhTail = 3'd3;
  localparam logic [2:0] PhSeek = 3'd4;

  logic [7:0] line_width, frame_lines, min_run_width, min_height;
  logic [2:0] state;
  blob_t table_q [MaxObjects];
  logic [MaxObjects-1:0] valid;
  logic [7:0] run_end_position, line_counter;
  logic [CountW-1:0] object_count;
  logic [SlotW-1:0] slot;
  logic [8:0] sum;
  logic [7:0] run_color, start, fin;
  logic track;
  logic [2:0] phase, field;

  // config port
  logic [1:0] reg_sel;
  assign reg_sel = paddr[3:2];
  assign pready = 1'b1;
  always_comb begin
    case (reg_sel)
      RegLineWidth:   prdata = {24'd0, line_width};
      RegFrameLines:  prdata = {24'd0, frame_lines};
      RegMinRunWidth: prdata = {24'd0, min_run_width};
      default:        prdata = {24'd0, min_height};
    endcase
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= 8'd176;
      frame_lines <= 8'd144;
      min_run_width <= 8'd3;
      min_height <= 8'd3;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        RegLineWidth:   line_width <= pwdata[7:0];
        RegFrameLines:  frame_lines <= pwdata[7:0];
        RegMinRunWidth: min_run_width <= pwdata[7:0];
        default:        min_height <= pwdata[7:0];
      endcase
    end
  end

  // shared compare unit on the current slot
  blob_t cur;
  logic merge_hit, filt_hit, slot_last;
  logic [7:0] prev_line, height, age;
  assign cur = table_q[slot];
  assign prev_line = line_counter - 8'd1;
  assign slot_last = (slot == SlotW'(MaxObjects - 1));
  assign height = cur.bottom - cur.top;
  assign age = line_counter - cur.bottom;
  always_comb begin
    merge_hit = valid[slot] && cur.color == run_color && line_counter != 8'd0 &&
                cur.bottom == prev_line &&
                ((start >= cur.span_lo && start <= cur.span_hi) ||
                 (fin >= cur.span_lo && fin <= cur.span_hi) ||
                 (start <= cur.span_lo && fin >= cur.span_hi));
    filt_hit = valid[slot] && cur.bottom >= cur.top && height < min_height &&
               line_counter >= cur.bottom && age > 8'd2;
  end

  // report byte selection
  logic [7:0] rep_byte;
  always_comb begin
    case (phase)
      PhHead:  rep_byte = PktHead;
      PhCount: rep_byte = 8'(object_count);
      PhTail:  rep_byte = PktTail;
      default: begin
        case (field)
          3'd0:    rep_byte = color_index(cur.color);
          3'd1:    rep_byte = cur.left;
          3'd2:    rep_byte = cur.top;
          3'd3:    rep_byte = cur.right;
          default: rep_byte = cur.bottom;
        endcase
      end
    endcase
  end

  // an empty table sends nothing: the head cycle only clears
  assign s_axis_tready = (state == StIdle);
  assign m_axis_tvalid = (state == StReport) && (phase != PhSeek) &&
                         !(phase == PhHead && object_count == '0);
  assign m_axis_tdata = rep_byte;
  assign m_axis_tlast = (phase == PhTail);

  logic [8:0] sum_in;
  logic [7:0] len_in;
  logic [7:0] line_next;
  assign len_in = s_axis_tdata[15:8];
  assign sum_in = {1'b0, run_end_position} + {1'b0, len_in};
  assign line_next = line_counter + 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      valid <= '0;
      object_count <= '0;
      line_counter <= '0;
      run_end_position <= '0;
      slot <= '0;
      phase <= PhHead;
      field <= '0;
    end else begin
      case (state)
        StIdle: begin
          if (s_axis_tvalid) begin
            if (s_axis_tuser) begin
              valid <= '0;
              object_count <= '0;
              line_counter <= '0;
              run_end_position <= '0;
            end else begin
              run_color <= s_axis_tdata[7:0];
              start <= run_end_position + 8'd1;
              sum <= sum_in;
              fin <= sum_in[8] ? 8'hFF : sum_in[7:0];
              track <= (s_axis_tdata[7:0] != 8'd0) && (len_in > min_run_width);
              slot <= '0;
              state <= StMerge;
            end
          end
        end
        StMerge: begin
          if (!track) begin
            state <= StLine;
          end else if (merge_hit) begin
            table_q[slot].span_lo <= start;
            table_q[slot].span_hi <= fin;
            if (cur.left > start) table_q[slot].left <= start;
            if (cur.right < fin) table_q[slot].right <= fin;
            table_q[slot].bottom <= line_counter;
            state <= StLine;
          end else if (slot_last) begin
            slot <= '0;
            state <= (object_count >= CountW'(MaxObjects)) ? StLine : StFree;
          end else begin
            slot <= slot + SlotW'(1);
          end
        end
        StFree: begin
          if (!valid[slot]) begin
            table_q[slot] <= '{color: run_color, span_lo: start, span_hi: fin,
                               left: start, top: line_counter, right: fin,
                               bottom: line_counter};
            valid[slot] <= 1'b1;
            object_count <= object_count + CountW'(1);
            state <= StLine;
          end else if (slot_last) begin
            state <= StLine;
          end else begin
            slot <= slot + SlotW'(1);
          end
        end
        StLine: begin
          slot <= '0;
          if (sum < {1'b0, line_width}) begin
            run_end_position <= sum[7:0];
            state <= StIdle;
          end else begin
            run_end_position <= '0;
            if (line_counter[2:0] == 3'd7) begin
              state <= StFilter;
            end else begin
              line_counter <= line_next;
              if (line_next < frame_lines && line_next != 8'd0) begin
                state <= StIdle;
              end else begin
                phase <= PhHead;
                state <= StReport;
              end
            end
          end
        end
        StFilter: begin
          if (filt_hit) begin
            valid[slot] <= 1'b0;
            if (object_count != '0) object_count <= object_count - CountW'(1);
          end
          if (slot_last) begin
            slot <= '0;
            line_counter <= line_next;
            if (line_next < frame_lines && line_next != 8'd0) begin
              state <= StIdle;
            end else begin
              phase <= PhHead;
              state <= StReport;
            end
          end else begin
            slot <= slot + SlotW'(1);
          end
        end
        StReport: begin
          if (phase == PhHead && object_count == '0) begin
            valid <= '0;
            line_counter <= '0;
            state <= StIdle;
          end else if (phase == PhSeek) begin
            field <= '0;
            if (valid[slot]) phase <= PhField;
            else if (slot_last) phase <= PhTail;
            else slot <= slot + SlotW'(1);
          end else if (m_axis_tready) begin
            case (phase)
              PhHead: phase <= PhCount;
              PhCount: begin
                slot <= '0;
                phase <= PhSeek;
              end
              PhField: begin
                if (field == 3'd4) begin
                  field <= '0;
                  if (slot_last) begin
                    phase <= PhTail;
                  end else begin
                    slot <= slot + SlotW'(1);
                    phase <= PhSeek;
                  end
                end else begin
                  field <= field + 3'd1;
                end
              end
              default: begin
                valid <= '0;
                object_count <= '0;
                line_counter <= '0;
                phase <= PhHead;
                state <= StIdle;
              end
            endcase
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

endmodule

// ===== test/tb.sv =====
// Testbench for run_length_blob_tracker: random and directed pixel runs against a
// behavioural predictor of the object table and frame report. Depends on rlbt_pkg.
// Inputs change on the falling edge, outputs are sampled on the rising edge.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rlbt_pkg::*;

  typedef struct {
    logic [7:0] color, span_lo, span_hi, left, top, right, bottom;
    bit valid;
  } obj_t;

  class report_board;
    obj_t tbl[MaxObjects];
    int unsigned run_pos, line_no, n_obj;
    int unsigned lw = 176, fl = 144, mrw = 3, mh = 3;
    logic [8:0] want_q[$];
    int mismatches;

    function void clear_frame();
      foreach (tbl[i]) tbl[i] = '{default: 0};
      n_obj = 0;
      line_no = 0;
      run_pos = 0;
    endfunction

    function logic [7:0] colour_code(logic [7:0] c);
      for (int k = 0; k < 8; k++) if (c == (8'd128 >> k)) return 8'(k);
      return 8'd0;
    endfunction

    function void place_run(logic [7:0] col, logic [7:0] st, logic [7:0] fn);
      bit hit;
      for (int i = 0; i < MaxObjects; i++) begin
        if (tbl[i].valid && tbl[i].color == col && line_no != 0 &&
            tbl[i].bottom == line_no - 1) begin
          hit = (st >= tbl[i].span_lo && st <= tbl[i].span_hi) ||
                (fn >= tbl[i].span_lo && fn <= tbl[i].span_hi) ||
                (st <= tbl[i].span_lo && fn >= tbl[i].span_hi);
          if (hit) begin
            tbl[i].span_lo = st;
            tbl[i].span_hi = fn;
            if (tbl[i].left > st) tbl[i].left = st;
            if (tbl[i].right < fn) tbl[i].right = fn;
            tbl[i].bottom = 8'(line_no);
            return;
          end
        end
      end
      if (n_obj >= MaxObjects) return;
      for (int i = 0; i < MaxObjects; i++) begin
        if (!tbl[i].valid) begin
          tbl[i] = '{col, st, fn, st, 8'(line_no), fn, 8'(line_no), 1'b1};
          n_obj++;
          return;
        end
      end
    endfunction

    function void note_request(bit act, logic [7:0] col, logic [7:0] len);
      int unsigned st, sum, fn;
      if (act) begin
        clear_frame();
        return;
      end
      st = run_pos + 1;
      sum = run_pos + len;
      fn = sum > 255 ? 255 : sum;
      if (col != 0 && len > mrw) place_run(col, 8'(st), 8'(fn));
      if (sum < lw) begin
        run_pos = sum;
        return;
      end
      run_pos = 0;
      if ((line_no & 7) == 7)
        foreach (tbl[i])
          if (tbl[i].valid && tbl[i].bottom >= tbl[i].top &&
              (tbl[i].bottom - tbl[i].top) < mh && line_no >= tbl[i].bottom &&
              line_no - tbl[i].bottom > 2) begin
            tbl[i].valid = 0;
            if (n_obj > 0) n_obj--;
          end
      line_no = (line_no + 1) & 8'hFF;
      if (line_no < fl && line_no != 0) return;
      if (n_obj > 0) begin
        want_q.push_back({1'b0, PktHead});
        want_q.push_back({1'b0, 8'(n_obj)});
        foreach (tbl[i])
          if (tbl[i].valid) begin
            want_q.push_back({1'b0, colour_code(tbl[i].color)});
            want_q.push_back({1'b0, tbl[i].left});
            want_q.push_back({1'b0, tbl[i].top});
            want_q.push_back({1'b0, tbl[i].right});
            want_q.push_back({1'b0, tbl[i].bottom});
          end
        want_q.push_back({1'b1, PktTail});
      end
      clear_frame();
    endfunction

    function void check_byte(logic [7:0] b, logic l);
      logic [8:0] w;
      if (want_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected byte %h last %b", b, l);
        return;
      end
      w = want_q.pop_front();
      if (w !== {l, b}) begin
        mismatches++;
        if (mismatches <= 10)
          $display("byte mismatch: expected %h last %b, got %h last %b",
                   w[7:0], w[8], b, l);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic s_axis_tvalid = 0, s_axis_tready, s_axis_tuser = 0;
  logic [15:0] s_axis_tdata = 0;
  logic m_axis_tvalid, m_axis_tready = 0, m_axis_tlast;
  logic [7:0] m_axis_tdata;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;

  report_board sb = new();
  int cycles;
  bit calm, holdoff;

  always #5 clk = ~clk;

  run_length_blob_tracker i_dut (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("run_length_blob_tracker regression: fail");
      $finish;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_byte(m_axis_tdata, m_axis_tlast);
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (holdoff) m_axis_tready <= 0;
    else m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 27);
  end

  task automatic write_reg(logic [1:0] idx, logic [7:0] v);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= {24'd0, v};
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      RegLineWidth: sb.lw = v;
      RegFrameLines: sb.fl = v;
      RegMinRunWidth: sb.mrw = v;
      default: sb.mh = v;
    endcase
  endtask

  // leaves tvalid high on return; the next request or drain() takes it
  task automatic send_run(bit act, logic [7:0] col, logic [7:0] len);
    while (!calm && $urandom_range(99) < 27) begin
      s_axis_tvalid <= 0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1; s_axis_tuser <= act; s_axis_tdata <= {len, col};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request(act, col, len);
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_colour();
    int r = $urandom_range(9);
    if (r == 0) return 8'd0;
    if (r == 9) return 8'($urandom);
    return 8'd1 << $urandom_range(7);
  endfunction

  // one phase of runs tiling lines in random colours, with pct_noise percent random runs or actions
  task automatic random_phase(int n_items, int pct_noise);
    logic [7:0] len;
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(99) < pct_noise) begin
        if ($urandom_range(9) == 0) send_run(1, 8'($urandom), 8'($urandom));
        else send_run(0, 8'($urandom), 8'($urandom));
      end else begin
        len = 8'($urandom_range(1, sb.lw > 8 ? sb.lw / 3 : 8));
        send_run(0, pick_colour(), len);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    calm = 1;
    // small frames, directed corner cases
    write_reg(RegLineWidth, 16);
    write_reg(RegFrameLines, 4);
    write_reg(RegMinRunWidth, 0);
    write_reg(RegMinHeight, 0);
    send_run(0, 8'd128, 8'd8);
    send_run(0, 8'd1, 8'd8);
    send_run(0, 8'd128, 8'd6);
    send_run(0, 8'd0, 8'd0);
    send_run(0, 8'd3, 8'd10);
    send_run(0, 8'd128, 8'd255);
    send_run(0, 8'd64, 8'd255);
    send_run(1, 8'hFF, 8'hFF);
    for (int k = 0; k < 9; k++) send_run(0, 8'd1 << (k % 8), 8'd16);
    send_run(0, 8'd2, 8'd255);
    drain();
    write_reg(RegLineWidth, 0);
    write_reg(RegFrameLines, 0);
    send_run(0, 8'd4, 8'd1);
    send_run(0, 8'd0, 8'd0);
    drain();
    write_reg(RegLineWidth, 255);
    write_reg(RegFrameLines, 1);
    write_reg(RegMinRunWidth, 255);
    send_run(0, 8'd8, 8'd255);
    drain();
    // random phases
    calm = 0;
    write_reg(RegLineWidth, 24);
    write_reg(RegFrameLines, 12);
    write_reg(RegMinRunWidth, 1);
    write_reg(RegMinHeight, 3);
    random_phase(150, 10);
    drain();
    write_reg(RegLineWidth, 12);
    write_reg(RegFrameLines, 20);
    write_reg(RegMinRunWidth, 2);
    write_reg(RegMinHeight, 255);
    holdoff = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        holdoff = 0;
      end
      random_phase(120, 5);
    join
    drain();
    calm = 1;
    write_reg(RegLineWidth, 40);
    write_reg(RegFrameLines, 6);
    write_reg(RegMinRunWidth, 0);
    write_reg(RegMinHeight, 1);
    random_phase(80, 10);
    drain();
    calm = 0;
    write_reg(RegLineWidth, 255);
    write_reg(RegFrameLines, 255);
    write_reg(RegMinHeight, 0);
    random_phase(130, 20);
    drain();
    if (sb.mismatches == 0 && sb.want_q.size() == 0)
      $display("run_length_blob_tracker regression: pass");
    else
      $display("run_length_blob_tracker regression: fail");
    $finish;
  end
endmodule
